@@ sv/vna_pkg.sv @@
package vna_pkg;

    localparam int VERTEX_DEPTH        = 1024;
    localparam int COORD_FRACTION_BITS = 16;
    localparam int ADDR_W              = $clog2(VERTEX_DEPTH);

    localparam int COORD_W = 24;
    localparam int SUM_W   = 32;
    localparam int POS_W   = 3 * COORD_W;
    localparam int SUMW_W  = 3 * SUM_W + 1;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef logic signed [COORD_W:0] t_diff;
    typedef logic signed [51:0]      t_vec;
    typedef logic        [51:0]      t_mag;

endpackage

@@ sv/vna_ram.sv @@
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vertex_normal_accumulator.sv @@
// channel   | handshake                | ports
// ----------+--------------------------+------------------------------------------
// command   | i_start & !o_busy        | i_opcode i_vertex_index i_pos_* i_corner_*
// result    | o_strobe (one cycle)     | o_normal_* o_read_index o_degenerate
//
// Write vertex: taken in its accept cycle, o_busy stays low. Clear all sums: o_busy stays
// high while the sum memory is swept. Triangle: busy for the shift steps, the 32-step square
// root, three 16-step divides and three corner updates; a flat face stops before the root.
// Read: busy on the same normalize path, ending early when degenerate; the result word is
// strobed in the cycle o_busy drops. After reset the sum memory is swept with o_busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module vertex_normal_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_vertex_index,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic [9:0]  i_corner_a,
    input  logic [9:0]  i_corner_b,
    input  logic [9:0]  i_corner_c,
    output logic        o_strobe,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [9:0]  o_read_index,
    output logic        o_degenerate
);

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RDSUM = 4'd2;
    localparam logic [3:0] S_PA    = 4'd3;
    localparam logic [3:0] S_PB    = 4'd4;
    localparam logic [3:0] S_PC    = 4'd5;
    localparam logic [3:0] S_CR    = 4'd6;
    localparam logic [3:0] S_MAG   = 4'd7;
    localparam logic [3:0] S_SHIFT = 4'd8;
    localparam logic [3:0] S_SQ    = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_DIVI  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_ARD   = 4'd13;
    localparam logic [3:0] S_AWR   = 4'd14;

    localparam int AW = vna_pkg::ADDR_W;
    localparam int CW = vna_pkg::COORD_W;
    localparam int SW = vna_pkg::SUM_W;

    logic [3:0]  r_state, n_state;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_comp, n_comp;
    logic [3:0]  r_step, n_step;
    logic [1:0]  r_op, n_op;
    logic [9:0]  r_idx, n_idx;
    logic [9:0]  r_ca, n_ca, r_cb, n_cb, r_cc, n_cc;
    logic [vna_pkg::POS_W-1:0] r_pa, n_pa;
    vna_pkg::t_diff r_d1 [3], n_d1 [3];
    vna_pkg::t_diff r_d2 [3], n_d2 [3];
    vna_pkg::t_vec  r_v  [3], n_v  [3];
    vna_pkg::t_mag  r_m  [3], n_m  [3];
    logic signed [63:0] r_acc, n_acc;
    logic [63:0] r_rem, n_rem, r_root, n_root, r_bit, n_bit;
    logic [47:0] r_drem, n_drem, r_dsh, n_dsh;
    logic [15:0] r_quo, n_quo;
    logic signed [15:0] r_q [3], n_q [3];
    logic        r_strobe, n_strobe, r_deg, n_deg;
    logic signed [15:0] r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic [9:0]  r_ridx, n_ridx;

    logic                         pos_we, sum_we;
    logic [AW-1:0]                pos_addr, sum_addr;
    logic [vna_pkg::POS_W-1:0]    pos_wdata, pos_rdata;
    logic [vna_pkg::SUMW_W-1:0]   sum_wdata, sum_rdata;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [63:0]        sq_try;
    logic [47:0]        div_sub;
    logic [15:0]        quo_next, quo_lim;
    logic signed [SW-1:0] old_s [3];
    logic signed [SW:0]   sum_w [3];
    logic signed [SW-1:0] sum_sat [3];
    logic signed [CW:0]   pb [3], pc [3];

    vna_ram #(.WIDTH(vna_pkg::POS_W), .DEPTH(vna_pkg::VERTEX_DEPTH)) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (pos_we),
        .i_addr (pos_addr),
        .i_wdata(pos_wdata),
        .o_rdata(pos_rdata)
    );

    vna_ram #(.WIDTH(vna_pkg::SUMW_W), .DEPTH(vna_pkg::VERTEX_DEPTH)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (sum_we),
        .i_addr (sum_addr),
        .i_wdata(sum_wdata),
        .o_rdata(sum_rdata)
    );

    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_CR) begin
            case (r_cnt)
                3'd0: begin mul_a = 32'(r_d1[1]); mul_b = 32'(r_d2[2]); end
                3'd1: begin mul_a = 32'(r_d1[2]); mul_b = 32'(r_d2[1]); end
                3'd2: begin mul_a = 32'(r_d1[2]); mul_b = 32'(r_d2[0]); end
                3'd3: begin mul_a = 32'(r_d1[0]); mul_b = 32'(r_d2[2]); end
                3'd4: begin mul_a = 32'(r_d1[0]); mul_b = 32'(r_d2[1]); end
                default: begin mul_a = 32'(r_d1[1]); mul_b = 32'(r_d2[0]); end
            endcase
        end else begin
            mul_a = {2'b00, r_m[r_comp][29:0]};
            mul_b = {2'b00, r_m[r_comp][29:0]};
        end
    end

    assign sq_try   = r_root + r_bit;
    assign div_sub  = r_drem - r_dsh;
    assign quo_next = {r_quo[14:0], (r_drem >= r_dsh)};
    assign quo_lim  = quo_next[15] ? 16'h7FFF : quo_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            old_s[i] = sum_rdata[vna_pkg::SUMW_W-1] ? sum_rdata[i*SW +: SW] : '0;
            sum_w[i] = (SW+1)'(old_s[i]) + (SW+1)'(r_q[i]);
            if (sum_w[i][SW] != sum_w[i][SW-1]) begin
                sum_sat[i] = sum_w[i][SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
                sum_sat[i] = sum_w[i][SW-1:0];
            end
            pb[i] = (CW+1)'($signed(pos_rdata[i*CW +: CW]));
            pc[i] = (CW+1)'($signed(r_pa[i*CW +: CW]));
        end
    end

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_cnt    = r_cnt;
        n_comp   = r_comp;
        n_step   = r_step;
        n_op     = r_op;
        n_idx    = r_idx;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_cc     = r_cc;
        n_pa     = r_pa;
        n_d1     = r_d1;
        n_d2     = r_d2;
        n_v      = r_v;
        n_m      = r_m;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_root   = r_root;
        n_bit    = r_bit;
        n_drem   = r_drem;
        n_dsh    = r_dsh;
        n_quo    = r_quo;
        n_q      = r_q;
        n_strobe = 1'b0;
        n_deg    = r_deg;
        n_nx     = r_nx;
        n_ny     = r_ny;
        n_nz     = r_nz;
        n_ridx   = r_ridx;
        pos_we    = 1'b0;
        pos_addr  = AW'(i_vertex_index);
        pos_wdata = {i_pos_z, i_pos_y, i_pos_x};
        sum_we    = 1'b0;
        sum_addr  = AW'(i_vertex_index);
        sum_wdata = '0;

        case (r_state)
            S_SWEEP: begin
                sum_we   = 1'b1;
                sum_addr = r_sweep;
                n_sweep  = r_sweep + 1'b1;
                if (r_sweep == AW'(vna_pkg::VERTEX_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_opcode;
                    n_idx = i_vertex_index;
                    n_ca  = i_corner_a;
                    n_cb  = i_corner_b;
                    n_cc  = i_corner_c;
                    case (i_opcode)
                        vna_pkg::OP_WRITE: begin
                            if (32'(i_vertex_index) < vna_pkg::VERTEX_DEPTH) begin
                                pos_we = 1'b1;
                                sum_we = 1'b1;
                            end
                        end
                        vna_pkg::OP_TRI: begin
                            pos_addr = AW'(i_corner_a);
                            if (32'(i_corner_a) < vna_pkg::VERTEX_DEPTH &&
                                32'(i_corner_b) < vna_pkg::VERTEX_DEPTH &&
                                32'(i_corner_c) < vna_pkg::VERTEX_DEPTH) begin
                                n_state = S_PA;
                            end
                        end
                        vna_pkg::OP_READ: begin
                            n_state = S_RDSUM;
                        end
                        default: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                    endcase
                end
            end
            S_RDSUM: begin
                if (32'(r_idx) < vna_pkg::VERTEX_DEPTH && sum_rdata[vna_pkg::SUMW_W-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        n_v[i] = 52'($signed(sum_rdata[i*SW +: SW]));
                    end
                    n_state = S_MAG;
                end else begin
                    n_strobe = 1'b1;
                    n_deg    = 1'b1;
                    n_nx     = '0;
                    n_ny     = '0;
                    n_nz     = '0;
                    n_ridx   = r_idx;
                    n_state  = S_IDLE;
                end
            end
            S_PA: begin
                n_pa     = pos_rdata;
                pos_addr = AW'(r_cb);
                n_state  = S_PB;
            end
            S_PB: begin
                for (int i = 0; i < 3; i++) n_d1[i] = pb[i] - pc[i];
                pos_addr = AW'(r_cc);
                n_state  = S_PC;
            end
            S_PC: begin
                for (int i = 0; i < 3; i++) n_d2[i] = pb[i] - pc[i];
                n_cnt   = '0;
                n_state = S_CR;
            end
            S_CR: begin
                n_cnt = r_cnt + 1'b1;
                if (!r_cnt[0]) begin
                    n_acc = mul_p;
                end else begin
                    n_v[r_cnt[2:1]] = 52'(r_acc - mul_p);
                end
                if (r_cnt == 3'd5) n_state = S_MAG;
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) n_m[i] = r_v[i][51] ? 52'(-r_v[i]) : 52'(r_v[i]);
                if (r_v[0] == '0 && r_v[1] == '0 && r_v[2] == '0) begin
                    if (r_op == vna_pkg::OP_READ) begin
                        n_strobe = 1'b1;
                        n_deg    = 1'b1;
                        n_nx     = '0;
                        n_ny     = '0;
                        n_nz     = '0;
                        n_ridx   = r_idx;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (|r_m[0][51:30] || |r_m[1][51:30] || |r_m[2][51:30]) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] >> 1;
                end else begin
                    n_acc   = '0;
                    n_comp  = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_acc  = r_acc + mul_p;
                n_comp = r_comp + 1'b1;
                if (r_comp == 2'd2) begin
                    n_rem   = 64'(r_acc + mul_p);
                    n_root  = '0;
                    n_bit   = 64'h4000_0000_0000_0000;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_rem >= sq_try) begin
                    n_rem  = r_rem - sq_try;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_comp  = '0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                n_drem  = {r_m[r_comp][29:0], 15'b0} + 48'(r_root[31:1]);
                n_dsh   = {1'b0, r_root[31:0], 15'b0};
                n_quo   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_drem >= r_dsh) n_drem = div_sub;
                n_quo  = quo_next;
                n_dsh  = r_dsh >> 1;
                n_step = r_step + 1'b1;
                if (r_step == 4'd15) begin
                    n_q[r_comp] = r_v[r_comp][51] ? -$signed(quo_lim) : $signed(quo_lim);
                    n_comp = r_comp + 1'b1;
                    if (r_comp != 2'd2) begin
                        n_state = S_DIVI;
                    end else if (r_op == vna_pkg::OP_READ) begin
                        n_strobe = 1'b1;
                        n_deg    = 1'b0;
                        n_nx     = r_q[0];
                        n_ny     = r_q[1];
                        n_nz     = r_v[2][51] ? -$signed(quo_lim) : $signed(quo_lim);
                        n_ridx   = r_idx;
                        n_state  = S_IDLE;
                    end else begin
                        n_comp  = '0;
                        n_state = S_ARD;
                    end
                end
            end
            S_ARD: begin
                sum_addr = (r_comp == 2'd0) ? AW'(r_ca) : (r_comp == 2'd1) ? AW'(r_cb) : AW'(r_cc);
                n_state  = S_AWR;
            end
            S_AWR: begin
                sum_addr  = (r_comp == 2'd0) ? AW'(r_ca) : (r_comp == 2'd1) ? AW'(r_cb) : AW'(r_cc);
                sum_we    = 1'b1;
                sum_wdata = {1'b1, sum_sat[2], sum_sat[1], sum_sat[0]};
                n_comp    = r_comp + 1'b1;
                n_state   = (r_comp == 2'd2) ? S_IDLE : S_ARD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_sweep  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_strobe <= n_strobe;
        end
        r_cnt  <= n_cnt;
        r_comp <= n_comp;
        r_step <= n_step;
        r_op   <= n_op;
        r_idx  <= n_idx;
        r_ca   <= n_ca;
        r_cb   <= n_cb;
        r_cc   <= n_cc;
        r_pa   <= n_pa;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
        r_v    <= n_v;
        r_m    <= n_m;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_drem <= n_drem;
        r_dsh  <= n_dsh;
        r_quo  <= n_quo;
        r_q    <= n_q;
        r_deg  <= n_deg;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_nz   <= n_nz;
        r_ridx <= n_ridx;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_read_index = r_ridx;
    assign o_degenerate = r_deg;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [1:0]         op;
        logic [9:0]         vidx;
        logic signed [23:0] px, py, pz;
        logic [9:0]         ca, cb, cc;
        int                 idle_pct;
        bit                 drain;
    } t_cmd_word;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic [9:0]         idx;
        logic               deg;
    } t_normal_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic [1:0]         i_opcode = vna_pkg::OP_WRITE;
    logic [9:0]         i_vertex_index = '0;
    logic signed [23:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [9:0]         i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic               o_busy, o_strobe, o_degenerate;
    logic signed [15:0] o_normal_x, o_normal_y, o_normal_z;
    logic [9:0]         o_read_index;

    vertex_normal_accumulator uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cmd_word    cmd_queue[$];
    t_normal_word normal_due[$];
    t_cmd_word    cur;

    // predictor state
    logic signed [23:0] vert_pos[vna_pkg::VERTEX_DEPTH][3];
    int                 acc_sum[vna_pkg::VERTEX_DEPTH][3];
    bit                 acc_live[vna_pkg::VERTEX_DEPTH];

    int errors = 0, n_reads = 0, n_tris = 0, n_flat = 0, n_clears = 0, n_degen = 0;
    int cycles = 0;
    bit gen_written[vna_pkg::VERTEX_DEPTH];
    int written_list[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root = 0, bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic bit unit_scale(input longint v[3], output int q[3]);
        longint unsigned m[3], mx = 0, sq = 0, len, r;
        int sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
            q[i] = 0;
        end
        if (mx == 0) return 1'b0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            sq += m[i] * m[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            r = (m[i] * 32768 + len / 2) / len;
            if (r > 32767) r = 32767;
            q[i] = v[i] < 0 ? -int'(r) : int'(r);
        end
        return 1'b1;
    endfunction

    function automatic void add_face(int k, int n[3]);
        longint t;
        if (!acc_live[k]) begin
            acc_sum[k] = '{0, 0, 0};
            acc_live[k] = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            t = longint'(acc_sum[k][i]) + n[i];
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            acc_sum[k][i] = int'(t);
        end
    endfunction

    task automatic accumulate(t_cmd_word w);
        longint d1[3], d2[3], cr[3], s[3];
        int n[3];
        int a, b, c;
        t_normal_word e;
        case (w.op)
            vna_pkg::OP_WRITE: begin
                vert_pos[w.vidx] = '{w.px, w.py, w.pz};
                acc_live[w.vidx] = 1'b0;
            end
            vna_pkg::OP_TRI: begin
                a = w.ca; b = w.cb; c = w.cc;
                for (int i = 0; i < 3; i++) begin
                    d1[i] = longint'(vert_pos[b][i]) - longint'(vert_pos[a][i]);
                    d2[i] = longint'(vert_pos[c][i]) - longint'(vert_pos[a][i]);
                end
                cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
                cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
                cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
                n_tris++;
                if (unit_scale(cr, n)) begin
                    add_face(a, n);
                    add_face(b, n);
                    add_face(c, n);
                end else begin
                    n_flat++;
                end
            end
            vna_pkg::OP_READ: begin
                n = '{0, 0, 0};
                e.deg = 1'b1;
                if (acc_live[w.vidx]) begin
                    for (int i = 0; i < 3; i++) s[i] = acc_sum[w.vidx][i];
                    e.deg = !unit_scale(s, n);
                end
                e.nx = n[0][15:0];
                e.ny = n[1][15:0];
                e.nz = n[2][15:0];
                e.idx = w.vidx;
                normal_due.insert(normal_due.size(), e);
            end
            default: begin
                acc_live = '{default: 1'b0};
                n_clears++;
            end
        endcase
    endtask

    task automatic report_mismatch(string field, int want, int got);
        $display("MISMATCH t=%0t %s: expected %0d got %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) accumulate(cur);
            if (!i_start || !o_busy) begin
                if (cmd_queue.size() > 0 && (!cmd_queue[0].drain || normal_due.size() == 0)
                    && $urandom_range(0, 99) >= cmd_queue[0].idle_pct) begin
                    cur = cmd_queue.pop_front();
                    i_opcode <= cur.op;
                    i_vertex_index <= cur.vidx;
                    i_pos_x <= cur.px;
                    i_pos_y <= cur.py;
                    i_pos_z <= cur.pz;
                    i_corner_a <= cur.ca;
                    i_corner_b <= cur.cb;
                    i_corner_c <= cur.cc;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_normal_word e;
        if (i_rst_n && o_strobe) begin
            if (normal_due.size() == 0) begin
                report_mismatch("pending result words", 0, 1);
            end else begin
                e = normal_due.pop_front();
                n_reads++;
                if (e.deg) n_degen++;
                if (o_normal_x !== e.nx) report_mismatch("normal_x", e.nx, o_normal_x);
                if (o_normal_y !== e.ny) report_mismatch("normal_y", e.ny, o_normal_y);
                if (o_normal_z !== e.nz) report_mismatch("normal_z", e.nz, o_normal_z);
                if (o_read_index !== e.idx) report_mismatch("read_index", e.idx, o_read_index);
                if (o_degenerate !== e.deg) report_mismatch("degenerate", e.deg, o_degenerate);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("vertex_normal_accumulator verification failed");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'(int'($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return 24'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic int pick_written();
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    task automatic add_cmd(logic [1:0] op, int vidx, logic signed [23:0] x, y, z,
                           int a, int b, int c, int idle, bit drain = 1'b0);
        t_cmd_word w;
        w.op = op; w.vidx = 10'(vidx); w.px = x; w.py = y; w.pz = z;
        w.ca = 10'(a); w.cb = 10'(b); w.cc = 10'(c); w.idle_pct = idle; w.drain = drain;
        if (op == vna_pkg::OP_WRITE && !gen_written[w.vidx]) begin
            gen_written[w.vidx] = 1'b1;
            written_list.insert(written_list.size(), int'(w.vidx));
        end
        cmd_queue.insert(cmd_queue.size(), w);
    endtask

    task automatic add_random(int idle, bit drain);
        int r, k;
        r = $urandom_range(0, 199);
        if (written_list.size() < 3 || r < 50) begin
            add_cmd(vna_pkg::OP_WRITE, $urandom_range(0, 1023), rand_coord(), rand_coord(),
                    rand_coord(), $urandom, $urandom, $urandom, idle, drain);
        end else if (r < 135) begin
            add_cmd(vna_pkg::OP_TRI, $urandom, 24'($urandom), 24'($urandom), 24'($urandom),
                    pick_written(), pick_written(), pick_written(), idle, drain);
        end else if (r < 198) begin
            k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : pick_written();
            add_cmd(vna_pkg::OP_READ, k, 24'($urandom), 24'($urandom), 24'($urandom),
                    $urandom, $urandom, $urandom, idle, drain);
        end else begin
            add_cmd(vna_pkg::OP_CLEAR, $urandom, 24'($urandom), 24'($urandom), 24'($urandom),
                    $urandom, $urandom, $urandom, idle, drain);
        end
    endtask

    initial begin
        int idle_by_phase[4] = '{0, 62, 0, 27};
        // directed: extremes, flat faces, repeated corners, clears
        add_cmd(vna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_WRITE, 1, 24'sh7FFFFF, -24'sh800000, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_WRITE, 2, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_WRITE, 1023, 24'sh10000, 0, 0, 1023, 1023, 1023, 0);
        add_cmd(vna_pkg::OP_WRITE, 512, 0, 24'sh10000, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 1, 2, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 1023, 512, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 0, 512, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 1023, 1023, 512, 0);
        add_cmd(vna_pkg::OP_WRITE, 3, 24'sh20000, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 0, 1023, 3, 0);
        add_cmd(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 1, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 512, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 3, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_WRITE, 512, 0, 24'sh10000, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 512, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(vna_pkg::OP_TRI, 0, 0, 0, 0, 2, 1, 0, 0);
        add_cmd(vna_pkg::OP_READ, 2, 0, 0, 0, 0, 0, 0, 0);
        for (int p = 0; p < 4; p++)
            for (int i = 0; i < 410; i++)
                add_random(idle_by_phase[p], p == 2 && i == 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (cmd_queue.size() == 0 && !i_start);
        wait (normal_due.size() == 0);
        repeat (1200) @(posedge i_clk);
        $display("Checked %0d normal reads (%0d degenerate) over %0d triangles",
                 n_reads, n_degen, n_tris);
        $display("%0d flat faces, %0d sum clears, %0d cycles", n_flat, n_clears, cycles);
        if (errors == 0 && normal_due.size() == 0) begin
            $display("vertex_normal_accumulator verification clean");
        end else begin
            $display("vertex_normal_accumulator verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/vna_pkg.sv
sv/vna_ram.sv
sv/vertex_normal_accumulator.sv
verif/testbench.sv
